/* hw/rtl/bed_pkg.sv */
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, codes and helpers for the edge deblocking segment filter.
// ----------------------------------------------------------------------------
package bed_pkg;

    // cap on the threshold before squaring for the inter tests
    localparam logic [2:0] NTT_CAP = 3'd5;

    typedef enum logic [1:0] {
        BR_NONE   = 2'd0,
        BR_INTRA  = 2'd1,
        BR_STRONG = 2'd2,
        BR_WEAK   = 2'd3
    } t_branch;

    typedef struct packed {
        logic [7:0] outer_e2;
        logic [7:0] outer_e1;
        logic [7:0] outer_e0;
        logic [7:0] inner_i0;
        logic [7:0] inner_i1;
        logic [7:0] inner_i2;
        logic [7:0] inner_i3;
        logic [8:0] threshold;
        logic       intra_mode;
        logic       outer_blend;
    } t_in_word;

    typedef struct packed {
        logic [7:0] new_e1;
        logic [7:0] new_e0;
        logic [7:0] new_i0;
        logic [7:0] new_i1;
        logic [7:0] new_i2;
        t_branch    branch_taken;
        logic       abandon_line;
    } t_out_word;

    // after stage 1: pixels, first-level tests, averages, weak filter taps
    typedef struct packed {
        logic [7:0] e2;
        logic [7:0] e1;
        logic [7:0] e0;
        logic [7:0] i0;
        logic [7:0] i1;
        logic [7:0] i2;
        logic [7:0] i3;
        logic [8:0] th;
        logic       th_nz;
        logic       intra;
        logic       blend;
        logic [4:0] ntt;
        logic [7:0] gi;
        logic [7:0] ge;
        logic       intra_p1;
        logic       inter_p1;
        logic [7:0] avg;
        logic [7:0] m;
        logic [7:0] w_e1;
        logic [7:0] w_e0;
        logic [7:0] w_i0;
        logic [7:0] w_i1;
    } t_s1_word;

    // after stage 2: decision plus every candidate value
    typedef struct packed {
        logic [7:0] e1;
        logic [7:0] e0;
        logic [7:0] i0;
        logic [7:0] i1;
        logic [7:0] i2;
        logic [7:0] avg;
        logic [7:0] b_e1;
        logic [7:0] b_i1;
        logic [7:0] s_i0;
        logic [7:0] s_i1;
        logic [7:0] s_i2;
        logic [7:0] w_e1;
        logic [7:0] w_e0;
        logic [7:0] w_i0;
        logic [7:0] w_i1;
        t_branch    branch;
        logic       abandon;
    } t_s2_word;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hw/rtl/bed_prep.sv */
// ----------------------------------------------------------------------------
// bed_prep
// Stage 1: edge differences, first-level tests, averages and weak filter taps.
// ----------------------------------------------------------------------------
module bed_prep
    import bed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s1_word o_data
);

    logic     r_valid;
    t_s1_word r_data;
    t_s1_word n_data;

    logic [2:0]  t5;
    logic [10:0] avg_sum;
    logic [9:0]  m_sum;
    logic [9:0]  we1_sum;
    logic [10:0] we0_sum;
    logic [10:0] wi0_sum;
    logic [9:0]  wi1_sum;

    always_comb begin
        n_data.e2    = i_data.outer_e2;
        n_data.e1    = i_data.outer_e1;
        n_data.e0    = i_data.outer_e0;
        n_data.i0    = i_data.inner_i0;
        n_data.i1    = i_data.inner_i1;
        n_data.i2    = i_data.inner_i2;
        n_data.i3    = i_data.inner_i3;
        n_data.th    = i_data.threshold;
        n_data.th_nz = (i_data.threshold != 9'd0);
        n_data.intra = i_data.intra_mode;
        n_data.blend = i_data.outer_blend;

        t5 = (i_data.threshold < 9'(NTT_CAP)) ? i_data.threshold[2:0] : NTT_CAP;
        n_data.ntt = 5'(6'(t5) * 6'(t5));

        n_data.gi = absdiff(i_data.inner_i0, i_data.inner_i1);
        n_data.ge = absdiff(i_data.outer_e0, i_data.outer_e1);
        n_data.intra_p1 = ({1'b0, absdiff(i_data.outer_e1, i_data.inner_i1)}
                           < i_data.threshold);
        n_data.inter_p1 = ({1'b0, absdiff(i_data.inner_i0, i_data.outer_e0)}
                           < {4'd0, n_data.ntt});

        avg_sum = 11'(i_data.outer_e2) + {2'd0, i_data.outer_e1, 1'b0}
                + 11'(i_data.outer_e0) + 11'(i_data.inner_i0)
                + {2'd0, i_data.inner_i1, 1'b0} + 11'(i_data.inner_i2) + 11'd4;
        n_data.avg = avg_sum[10:3];

        m_sum = 10'(i_data.outer_e0) + 10'(i_data.inner_i0)
              + 10'(i_data.outer_e1) + 10'(i_data.inner_i1) + 10'd2;
        n_data.m = m_sum[9:2];

        we1_sum = 10'(i_data.outer_e2) + 10'(i_data.outer_e1)
                + 10'(i_data.outer_e0) + 10'(i_data.inner_i0) + 10'd2;
        we0_sum = 11'(i_data.outer_e2) + {2'd0, i_data.outer_e1, 1'b0}
                + {2'd0, i_data.outer_e0, 1'b0} + {2'd0, i_data.inner_i0, 1'b0}
                + 11'(i_data.inner_i1) + 11'd4;
        wi0_sum = 11'(i_data.inner_i2) + {2'd0, i_data.inner_i1, 1'b0}
                + {2'd0, i_data.inner_i0, 1'b0} + {2'd0, i_data.outer_e0, 1'b0}
                + 11'(i_data.outer_e1) + 11'd4;
        wi1_sum = 10'(i_data.inner_i2) + 10'(i_data.inner_i1)
                + 10'(i_data.inner_i0) + 10'(i_data.outer_e0) + 10'd2;
        n_data.w_e1 = we1_sum[9:2];
        n_data.w_e0 = we0_sum[10:3];
        n_data.w_i0 = wi0_sum[10:3];
        n_data.w_i1 = wi1_sum[9:2];
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/bed_decide.sv */
// ----------------------------------------------------------------------------
// bed_decide
// Stage 2: second-level tests, branch choice, strong and blend candidates.
// ----------------------------------------------------------------------------
module bed_decide
    import bed_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_s1_word i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s2_word o_data
);

    logic     r_valid;
    t_s2_word r_data;
    t_s2_word n_data;

    logic        intra_p2;
    logic        strong_ok;
    logic        grad_fail;
    logic [8:0]  be1_sum;
    logic [8:0]  bi1_sum;
    logic [10:0] si0_sum;
    logic [9:0]  si1_sum;
    logic [10:0] si2_sum;

    always_comb begin
        intra_p2 = ({1'b0, absdiff(i_data.e1, i_data.avg)} < i_data.th)
                && ({1'b0, absdiff(i_data.e2, i_data.avg)} < i_data.th)
                && ({1'b0, absdiff(i_data.i1, i_data.avg)} < i_data.th)
                && ({1'b0, absdiff(i_data.i2, i_data.avg)} < i_data.th);
        strong_ok = ({i_data.gi, 2'b00} < {5'd0, i_data.ntt})
                 && ({i_data.ge, 2'b00} < {5'd0, i_data.ntt});
        grad_fail = (i_data.gi >= {3'd0, i_data.ntt})
                 || (i_data.ge >= {3'd0, i_data.ntt});

        // blend the average with e2 and i2 when blend is set, else with e1 and i1
        be1_sum = 9'(i_data.avg) + 9'(i_data.blend ? i_data.e2 : i_data.e1) + 9'd1;
        bi1_sum = 9'(i_data.avg) + 9'(i_data.blend ? i_data.i2 : i_data.i1) + 9'd1;

        si0_sum = 11'(i_data.i2) + {2'd0, i_data.i1, 1'b0} + {1'b0, i_data.m, 2'b00}
                + 11'(i_data.e1) + 11'd4;
        si1_sum = 10'(i_data.i2) + 10'(i_data.i1) + {1'b0, i_data.m, 1'b0} + 10'd2;
        si2_sum = {2'd0, i_data.i3, 1'b0} + {2'd0, i_data.i2, 1'b0} + 11'(i_data.i2)
                + 11'(i_data.i1) + {2'd0, i_data.m, 1'b0} + 11'd4;

        n_data.e1   = i_data.e1;
        n_data.e0   = i_data.e0;
        n_data.i0   = i_data.i0;
        n_data.i1   = i_data.i1;
        n_data.i2   = i_data.i2;
        n_data.avg  = i_data.avg;
        n_data.b_e1 = be1_sum[8:1];
        n_data.b_i1 = bi1_sum[8:1];
        n_data.s_i0 = si0_sum[10:3];
        n_data.s_i1 = si1_sum[9:2];
        n_data.s_i2 = si2_sum[10:3];
        n_data.w_e1 = i_data.w_e1;
        n_data.w_e0 = i_data.w_e0;
        n_data.w_i0 = i_data.w_i0;
        n_data.w_i1 = i_data.w_i1;

        n_data.branch  = BR_NONE;
        n_data.abandon = 1'b0;
        if (i_data.th_nz) begin
            if (i_data.intra) begin
                if (i_data.intra_p1) begin
                    if (intra_p2) begin
                        n_data.branch = BR_INTRA;
                    end else begin
                        n_data.abandon = 1'b1;
                    end
                end
            end else if (i_data.inter_p1) begin
                if (strong_ok) begin
                    n_data.branch = BR_STRONG;
                end else if (grad_fail) begin
                    n_data.abandon = 1'b1;
                end else begin
                    n_data.branch = BR_WEAK;
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/bed_select.sv */
// ----------------------------------------------------------------------------
// bed_select
// Stage 3: pick the pixels of the taken branch into the output register.
// ----------------------------------------------------------------------------
module bed_select
    import bed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_s2_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;
    t_out_word n_data;

    always_comb begin
        n_data.new_e1       = i_data.e1;
        n_data.new_e0       = i_data.e0;
        n_data.new_i0       = i_data.i0;
        n_data.new_i1       = i_data.i1;
        n_data.new_i2       = i_data.i2;
        n_data.branch_taken = i_data.branch;
        n_data.abandon_line = i_data.abandon;
        case (i_data.branch)
            BR_INTRA: begin
                n_data.new_e1 = i_data.b_e1;
                n_data.new_e0 = i_data.avg;
                n_data.new_i0 = i_data.avg;
                n_data.new_i1 = i_data.b_i1;
            end
            BR_STRONG: begin
                n_data.new_i0 = i_data.s_i0;
                n_data.new_i1 = i_data.s_i1;
                n_data.new_i2 = i_data.s_i2;
            end
            BR_WEAK: begin
                n_data.new_e1 = i_data.w_e1;
                n_data.new_e0 = i_data.w_e0;
                n_data.new_i0 = i_data.w_i0;
                n_data.new_i1 = i_data.w_i1;
            end
            default: begin
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/block_edge_deblock_segment.sv */
// ----------------------------------------------------------------------------
// block_edge_deblock_segment
// Deblocking filter for one seven-pixel segment across a block edge.
// ----------------------------------------------------------------------------
// Takes one segment word per clock while o_in_ready is high and returns one
// result word per segment, in order, from the output register.
// The three register stages (edge tests and averages, branch decision and
// filter candidates, pixel selection into the output register) each hold
// one word, so a stalled output keeps taking input until all three fill.
module block_edge_deblock_segment
    import bed_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic     s1_valid;
    logic     s1_ready;
    t_s1_word s1_data;
    logic     s2_valid;
    logic     s2_ready;
    t_s2_word s2_data;

    bed_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_word),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    bed_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    bed_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_word)
    );

    // a filtered word never flags the line as abandoned
    a_branch_no_abandon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.branch_taken != BR_NONE) |-> !o_out_word.abandon_line)
        else $error("branch taken together with abandon");

    // hold stage 1 while stage 2 is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_data))
        else $error("stage 1 word lost under stall");

    // hold stage 2 while the output register is stalled
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_data))
        else $error("stage 2 word lost under stall");

    // a first stage that is empty or passing its word on always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_valid || s1_ready |-> o_in_ready)
        else $error("input stalled with room in stage 1");

endmodule

/* verif/block_edge_deblock_segment_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_edge_deblock_segment_tb
// Self-checking bench for the seven-pixel edge deblocking filter.
// ----------------------------------------------------------------------------
// Runs a short table of edge cases first: zero threshold, failed first and
// second level tests, flat and saturated segments in both modes, and
// threshold caps. A stream of random segments follows. Most of them are
// smooth segments that reach the filter branches, and the rest are noise.
// Each accepted segment is predicted here and queued. Each output word is
// compared field by field against the oldest prediction. Both handshakes
// idle and stall at random.
// ----------------------------------------------------------------------------
module block_edge_deblock_segment_tb;
    import bed_pkg::*;

    localparam int N_DIR        = 20;
    localparam int N_RANDOM     = 1750;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        t_in_word  seg;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    localparam t_out_word NO_CHECK = '0;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    t_out_word filtered_due[$];
    bit        hold_typed;
    t_out_word hold_want;
    bit        no_idle;
    int        n_fail;
    int        idle_cycles;

    // e2 e1 e0 i0 i1 i2 i3 threshold intra blend
    t_dir_row dir_table [N_DIR] = '{
        '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 1'b0, 1'b0}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, BR_NONE, 1'b0}},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 9'd0, 1'b1, 1'b1},
          1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, BR_NONE, 1'b0}},
        '{'{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 9'd511, 1'b1, 1'b0},
          1'b1, '{8'd100, 8'd100, 8'd100, 8'd100, 8'd100, BR_INTRA, 1'b0}},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 1'b1, 1'b1},
          1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, BR_INTRA, 1'b0}},
        '{'{8'd10, 8'd40, 8'd60, 8'd70, 8'd90, 8'd120, 8'd200, 9'd511, 1'b1, 1'b1},
          1'b0, NO_CHECK},
        // intra, outer and inner taps too far apart
        '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 9'd10, 1'b1, 1'b0}, 1'b1,
          '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0, BR_NONE, 1'b0}},
        // intra, far pixels off the average: abandon
        '{'{8'd0, 8'd100, 8'd100, 8'd100, 8'd100, 8'd0, 8'd0, 9'd20, 1'b1, 1'b0}, 1'b1,
          '{8'd100, 8'd100, 8'd100, 8'd100, 8'd0, BR_NONE, 1'b1}},
        '{'{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 9'd511, 1'b0, 1'b0},
          1'b1, '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, BR_STRONG, 1'b0}},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 9'd511, 1'b0, 1'b1},
          1'b1, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, BR_STRONG, 1'b0}},
        '{'{8'd120, 8'd126, 8'd128, 8'd129, 8'd131, 8'd133, 8'd0, 9'd5, 1'b0, 1'b0},
          1'b0, NO_CHECK},
        '{'{8'd50, 8'd50, 8'd50, 8'd50, 8'd57, 8'd60, 8'd60, 9'd5, 1'b0, 1'b0},
          1'b0, NO_CHECK},
        // inter, steep inner gradient: abandon
        '{'{8'd50, 8'd50, 8'd50, 8'd50, 8'd80, 8'd80, 8'd80, 9'd9, 1'b0, 1'b0}, 1'b1,
          '{8'd50, 8'd50, 8'd50, 8'd80, 8'd80, BR_NONE, 1'b1}},
        // inter, edge step equal to ntt
        '{'{8'd50, 8'd50, 8'd50, 8'd75, 8'd75, 8'd75, 8'd75, 9'd5, 1'b0, 1'b0}, 1'b1,
          '{8'd50, 8'd50, 8'd75, 8'd75, 8'd75, BR_NONE, 1'b0}},
        '{'{8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 9'd1, 1'b0, 1'b0}, 1'b0, NO_CHECK},
        '{'{8'd60, 8'd62, 8'd64, 8'd67, 8'd68, 8'd70, 8'd71, 9'd4, 1'b0, 1'b0},
          1'b0, NO_CHECK},
        '{'{8'd60, 8'd60, 8'd60, 8'd64, 8'd70, 8'd70, 8'd70, 9'd6, 1'b0, 1'b0},
          1'b0, NO_CHECK},
        '{'{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 9'd511, 1'b1, 1'b0},
          1'b0, NO_CHECK},
        '{'{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 9'd511, 1'b0, 1'b1},
          1'b0, NO_CHECK},
        '{'{8'd90, 8'd91, 8'd90, 8'd90, 8'd91, 8'd92, 8'd3, 9'd1, 1'b1, 1'b1},
          1'b0, NO_CHECK},
        '{'{8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 9'h1AA, 1'b1, 1'b0},
          1'b0, NO_CHECK}
    };

    block_edge_deblock_segment uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int unsigned pix_dist(input int unsigned a, input int unsigned b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_out_word deblock_segment(input t_in_word w);
        int unsigned e2, e1, e0, i0, i1, i2, i3, th, cap, ntt, avg, gi, ge, m;
        t_out_word r;
        e2 = 32'(w.outer_e2);
        e1 = 32'(w.outer_e1);
        e0 = 32'(w.outer_e0);
        i0 = 32'(w.inner_i0);
        i1 = 32'(w.inner_i1);
        i2 = 32'(w.inner_i2);
        i3 = 32'(w.inner_i3);
        th = 32'(w.threshold);
        r.new_e1       = w.outer_e1;
        r.new_e0       = w.outer_e0;
        r.new_i0       = w.inner_i0;
        r.new_i1       = w.inner_i1;
        r.new_i2       = w.inner_i2;
        r.branch_taken = BR_NONE;
        r.abandon_line = 1'b0;
        if (th != 0) begin
            cap = (th < 32'(NTT_CAP)) ? th : 32'(NTT_CAP);
            ntt = cap * cap;
            if (w.intra_mode && pix_dist(e1, i1) < th) begin
                avg = (e2 + 2 * e1 + e0 + i0 + 2 * i1 + i2 + 4) >> 3;
                if (pix_dist(e1, avg) < th && pix_dist(e2, avg) < th &&
                    pix_dist(i1, avg) < th && pix_dist(i2, avg) < th) begin
                    if (w.outer_blend) begin
                        r.new_e1 = 8'((avg + e2 + 1) >> 1);
                        r.new_i1 = 8'((avg + i2 + 1) >> 1);
                    end else begin
                        r.new_e1 = 8'((avg + e1 + 1) >> 1);
                        r.new_i1 = 8'((avg + i1 + 1) >> 1);
                    end
                    r.new_e0       = 8'(avg);
                    r.new_i0       = 8'(avg);
                    r.branch_taken = BR_INTRA;
                end else begin
                    r.abandon_line = 1'b1;
                end
            end else if (!w.intra_mode && pix_dist(i0, e0) < ntt) begin
                gi = pix_dist(i0, i1);
                ge = pix_dist(e0, e1);
                if ((gi << 2) < ntt && (ge << 2) < ntt) begin
                    m = (e0 + i0 + e1 + i1 + 2) >> 2;
                    r.new_i0       = 8'((i2 + 2 * i1 + 4 * m + e1 + 4) >> 3);
                    r.new_i1       = 8'((i2 + i1 + 2 * m + 2) >> 2);
                    r.new_i2       = 8'((2 * i3 + 3 * i2 + i1 + 2 * m + 4) >> 3);
                    r.branch_taken = BR_STRONG;
                end else if (gi >= ntt || ge >= ntt) begin
                    r.abandon_line = 1'b1;
                end else begin
                    r.new_e1       = 8'((e2 + e1 + e0 + i0 + 2) >> 2);
                    r.new_e0       = 8'((e2 + 2 * e1 + 2 * e0 + 2 * i0 + i1 + 4) >> 3);
                    r.new_i0       = 8'((i2 + 2 * i1 + 2 * i0 + 2 * e0 + e1 + 4) >> 3);
                    r.new_i1       = 8'((i2 + i1 + i0 + e0 + 2) >> 2);
                    r.branch_taken = BR_WEAK;
                end
            end
        end
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [7:0] near_pixel(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // segments around a random level, mostly smooth so the filter branches get hit
    function automatic t_in_word random_segment();
        int          base;
        int          spread;
        int unsigned pick;
        t_in_word    w;
        base   = int'($urandom_range(0, 255));
        pick   = $urandom_range(0, 9);
        spread = (pick < 4) ? 2 : (pick < 7) ? 8 : (pick < 9) ? 40 : 255;
        w.outer_e2 = near_pixel(base, spread);
        w.outer_e1 = near_pixel(base, spread);
        w.outer_e0 = near_pixel(base, spread);
        w.inner_i0 = near_pixel(base, spread);
        w.inner_i1 = near_pixel(base, spread);
        w.inner_i2 = near_pixel(base, spread);
        w.inner_i3 = near_pixel(base, spread);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            w.threshold = 9'd0;
        else if (pick < 40)
            w.threshold = 9'($urandom_range(1, 6));
        else if (pick < 80)
            w.threshold = 9'($urandom_range(7, 60));
        else if (pick < 95)
            w.threshold = 9'($urandom_range(61, 511));
        else
            w.threshold = 9'd511;
        w.intra_mode  = 1'($urandom_range(0, 1));
        w.outer_blend = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic check_result(input t_out_word got, input t_out_word want);
        if (got.new_e1 !== want.new_e1) begin
            $error("new_e1: expected %0d, got %0d", want.new_e1, got.new_e1);
            n_fail++;
        end
        if (got.new_e0 !== want.new_e0) begin
            $error("new_e0: expected %0d, got %0d", want.new_e0, got.new_e0);
            n_fail++;
        end
        if (got.new_i0 !== want.new_i0) begin
            $error("new_i0: expected %0d, got %0d", want.new_i0, got.new_i0);
            n_fail++;
        end
        if (got.new_i1 !== want.new_i1) begin
            $error("new_i1: expected %0d, got %0d", want.new_i1, got.new_i1);
            n_fail++;
        end
        if (got.new_i2 !== want.new_i2) begin
            $error("new_i2: expected %0d, got %0d", want.new_i2, got.new_i2);
            n_fail++;
        end
        if (got.branch_taken !== want.branch_taken) begin
            $error("branch_taken: expected %0d, got %0d", want.branch_taken,
                   got.branch_taken);
            n_fail++;
        end
        if (got.abandon_line !== want.abandon_line) begin
            $error("abandon_line: expected %0d, got %0d", want.abandon_line,
                   got.abandon_line);
            n_fail++;
        end
    endtask

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_segment(input t_in_word w, input bit typed, input t_out_word want);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        hold_typed <= typed;
        hold_want  <= want;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // scoreboard: retire output words first, then queue the accepted segment
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (filtered_due.size() == 0) begin
                    $error("output word with no segment pending");
                    n_fail++;
                end else begin
                    check_result(o_out_word, filtered_due.pop_front());
                end
            end
            if (i_in_valid && o_in_ready)
                filtered_due.push_back(hold_typed ? hold_want : deblock_segment(i_in_word));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        hold_typed  = 1'b0;
        hold_want   = '0;
        no_idle     = 1'b0;
        n_fail      = 0;
        idle_cycles = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIR; k++)
            send_segment(dir_table[k].seg, dir_table[k].typed, dir_table[k].want);

        for (int k = 0; k < N_RANDOM; k++) begin
            no_idle = (k >= 700 && k < 900);
            // hold off until the pipeline has drained
            if (k % 500 == 499) begin
                i_in_valid <= 1'b0;
                while (filtered_due.size() != 0)
                    @(negedge i_clk);
                @(negedge i_clk);
            end
            send_segment(random_segment(), 1'b0, NO_CHECK);
        end

        i_in_valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (filtered_due.size() != 0) begin
            $error("%0d segments never produced an output word", filtered_due.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* block_edge_deblock_segment.f */
hw/rtl/bed_pkg.sv
hw/rtl/bed_prep.sv
hw/rtl/bed_decide.sv
hw/rtl/bed_select.sv
hw/rtl/block_edge_deblock_segment.sv
verif/block_edge_deblock_segment_tb.sv
